@@ hw/rtl/atf_pkg.sv @@
// ----------------------------------------------------------------------------
// atf_pkg
// Shared constants and types for the API transmit frame builder.
// ----------------------------------------------------------------------------
package atf_pkg;

  localparam int unsigned ADDR_W = 16;
  localparam int unsigned LEN_W  = 16;
  localparam int unsigned BYTE_W = 8;
  localparam int unsigned STEP_W = 4;

  localparam logic [BYTE_W-1:0] START_BYTE   = 8'h7E;
  localparam logic [BYTE_W-1:0] API_ID_TX16  = 8'h01;
  localparam logic [BYTE_W-1:0] FRAME_ID     = 8'h01;
  localparam logic [BYTE_W-1:0] OPTIONS_BYTE = 8'h00;
  localparam logic [BYTE_W-1:0] CSUM_BASE    = 8'hFF;
  localparam logic [LEN_W-1:0]  LEN_OVERHEAD = 16'd5;

  // Sequencer steps: header bytes, then payload byte, then checksum.
  localparam logic [STEP_W-1:0] STEP_START  = 4'd0;
  localparam logic [STEP_W-1:0] STEP_LEN_HI = 4'd1;
  localparam logic [STEP_W-1:0] STEP_LEN_LO = 4'd2;
  localparam logic [STEP_W-1:0] STEP_API_ID = 4'd3;
  localparam logic [STEP_W-1:0] STEP_FRM_ID = 4'd4;
  localparam logic [STEP_W-1:0] STEP_ADR_HI = 4'd5;
  localparam logic [STEP_W-1:0] STEP_ADR_LO = 4'd6;
  localparam logic [STEP_W-1:0] STEP_OPTS   = 4'd7;
  localparam logic [STEP_W-1:0] STEP_DATA   = 4'd8;
  localparam logic [STEP_W-1:0] STEP_CSUM   = 4'd9;

  typedef struct packed {
    logic [BYTE_W-1:0] frame_byte;
    logic              last_of_run;
    logic              end_of_frame;
  } res_t;

endpackage

@@ hw/rtl/atf_seq.sv @@
// ----------------------------------------------------------------------------
// atf_seq
// Holds one input item and emits its bytes, one per cycle when not stalled.
// ----------------------------------------------------------------------------
module atf_seq (
  input  logic                              clk,
  input  logic                              rst_n,
  input  logic                              in_valid,
  output logic                              in_stall,
  input  logic [atf_pkg::ADDR_W-1:0]        in_dest_addr,
  input  logic [atf_pkg::LEN_W-1:0]         in_payload_len,
  input  logic [atf_pkg::BYTE_W-1:0]        in_data_byte,
  input  logic                              emit_ready,
  output logic                              emit_valid,
  output atf_pkg::res_t                     emit_res
);

  logic                        hold_v_r, hold_v_nxt;
  logic [atf_pkg::ADDR_W-1:0]  addr_r, addr_nxt;
  logic [atf_pkg::LEN_W-1:0]   plen_r, plen_nxt;
  logic [atf_pkg::BYTE_W-1:0]  data_r, data_nxt;
  logic [atf_pkg::STEP_W-1:0]  step_r, step_nxt;
  logic                        in_frame_r, in_frame_nxt;
  logic [atf_pkg::LEN_W-1:0]   rem_r, rem_nxt;
  logic [atf_pkg::BYTE_W-1:0]  sum_r, sum_nxt;

  logic [atf_pkg::STEP_W-1:0]  eff_step;
  logic [atf_pkg::STEP_W-1:0]  step_c;
  logic                        in_frame_c;
  logic [atf_pkg::LEN_W-1:0]   rem_c;
  logic [atf_pkg::BYTE_W-1:0]  sum_c;
  logic [atf_pkg::LEN_W-1:0]   flen;
  logic [atf_pkg::BYTE_W-1:0]  byte_c;
  logic                        last_c;
  logic                        eof_c;
  logic                        fire;
  logic                        accept;

  assign flen     = plen_r + atf_pkg::LEN_OVERHEAD;
  assign fire     = hold_v_r && emit_ready;
  assign in_stall = hold_v_r && !(fire && last_c);
  assign accept   = in_valid && !in_stall;

  always_comb begin
    eff_step = step_r;
    if (step_r == atf_pkg::STEP_START && in_frame_r) begin
      eff_step = (rem_r != '0) ? atf_pkg::STEP_DATA : atf_pkg::STEP_CSUM;
    end
  end

  always_comb begin
    step_c     = eff_step + 4'd1;
    in_frame_c = in_frame_r;
    rem_c      = rem_r;
    sum_c      = sum_r;
    byte_c     = '0;
    last_c     = 1'b0;
    eof_c      = 1'b0;
    case (eff_step)
      atf_pkg::STEP_START: begin
        byte_c = atf_pkg::START_BYTE;
        sum_c  = '0;
      end
      atf_pkg::STEP_LEN_HI: begin
        byte_c = flen[15:8];
      end
      atf_pkg::STEP_LEN_LO: begin
        byte_c = flen[7:0];
      end
      atf_pkg::STEP_API_ID: begin
        byte_c = atf_pkg::API_ID_TX16;
        sum_c  = sum_r + byte_c;
      end
      atf_pkg::STEP_FRM_ID: begin
        byte_c = atf_pkg::FRAME_ID;
        sum_c  = sum_r + byte_c;
      end
      atf_pkg::STEP_ADR_HI: begin
        byte_c = addr_r[15:8];
        sum_c  = sum_r + byte_c;
      end
      atf_pkg::STEP_ADR_LO: begin
        byte_c = addr_r[7:0];
        sum_c  = sum_r + byte_c;
      end
      atf_pkg::STEP_OPTS: begin
        byte_c     = atf_pkg::OPTIONS_BYTE;
        sum_c      = sum_r + byte_c;
        in_frame_c = 1'b1;
        rem_c      = plen_r;
        step_c     = (plen_r != '0) ? atf_pkg::STEP_DATA : atf_pkg::STEP_CSUM;
      end
      atf_pkg::STEP_DATA: begin
        byte_c = data_r;
        sum_c  = sum_r + data_r;
        rem_c  = rem_r - 16'd1;
        step_c = atf_pkg::STEP_CSUM;
        last_c = (rem_r != 16'd1);
      end
      atf_pkg::STEP_CSUM: begin
        byte_c     = atf_pkg::CSUM_BASE - sum_r;
        last_c     = 1'b1;
        eof_c      = 1'b1;
        in_frame_c = 1'b0;
        sum_c      = '0;
        step_c     = atf_pkg::STEP_START;
      end
      default: begin
        last_c = 1'b1;
        step_c = atf_pkg::STEP_START;
      end
    endcase
  end

  always_comb begin
    hold_v_nxt   = hold_v_r;
    addr_nxt     = addr_r;
    plen_nxt     = plen_r;
    data_nxt     = data_r;
    step_nxt     = step_r;
    in_frame_nxt = in_frame_r;
    rem_nxt      = rem_r;
    sum_nxt      = sum_r;
    if (fire) begin
      step_nxt     = last_c ? atf_pkg::STEP_START : step_c;
      in_frame_nxt = in_frame_c;
      rem_nxt      = rem_c;
      sum_nxt      = sum_c;
      if (last_c) begin
        hold_v_nxt = 1'b0;
      end
    end
    if (accept) begin
      hold_v_nxt = 1'b1;
      addr_nxt   = in_dest_addr;
      plen_nxt   = in_payload_len;
      data_nxt   = in_data_byte;
      step_nxt   = atf_pkg::STEP_START;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      hold_v_r   <= 1'b0;
      step_r     <= atf_pkg::STEP_START;
      in_frame_r <= 1'b0;
      rem_r      <= '0;
      sum_r      <= '0;
    end else begin
      hold_v_r   <= hold_v_nxt;
      step_r     <= step_nxt;
      in_frame_r <= in_frame_nxt;
      rem_r      <= rem_nxt;
      sum_r      <= sum_nxt;
    end
  end

  always_ff @(posedge clk) begin
    addr_r <= addr_nxt;
    plen_r <= plen_nxt;
    data_r <= data_nxt;
  end

  assign emit_valid            = hold_v_r;
  assign emit_res.frame_byte   = byte_c;
  assign emit_res.last_of_run  = last_c;
  assign emit_res.end_of_frame = eof_c;

endmodule

@@ hw/rtl/atf_out_reg.sv @@
// ----------------------------------------------------------------------------
// atf_out_reg
// Result register toward the byte consumer; holds its item while stalled.
// ----------------------------------------------------------------------------
module atf_out_reg (
  input  logic                       clk,
  input  logic                       rst_n,
  input  logic                       emit_valid,
  input  atf_pkg::res_t              emit_res,
  output logic                       emit_ready,
  output logic                       out_valid,
  input  logic                       out_stall,
  output logic [atf_pkg::BYTE_W-1:0] out_frame_byte,
  output logic                       out_last_of_run,
  output logic                       out_end_of_frame
);

  logic          valid_r, valid_nxt;
  atf_pkg::res_t res_r, res_nxt;

  assign emit_ready = !valid_r || !out_stall;

  always_comb begin
    valid_nxt = valid_r;
    res_nxt   = res_r;
    if (emit_ready) begin
      valid_nxt = emit_valid;
      res_nxt   = emit_res;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      valid_r <= 1'b0;
    end else begin
      valid_r <= valid_nxt;
    end
  end

  always_ff @(posedge clk) begin
    res_r <= res_nxt;
  end

  assign out_valid        = valid_r;
  assign out_frame_byte   = res_r.frame_byte;
  assign out_last_of_run  = res_r.last_of_run;
  assign out_end_of_frame = res_r.end_of_frame;

endmodule

@@ hw/rtl/api_tx16_frame_builder.sv @@
// ----------------------------------------------------------------------------
// api_tx16_frame_builder
// Builds API transmit request frames with a 16-bit destination and checksum.
// ----------------------------------------------------------------------------
// Input channel (in_*): one item per payload byte. The first item of a frame
// also carries the destination address and payload length; it causes the
// 8-byte header, its payload byte if the length is not zero, and the checksum
// if the frame ends there. Every later item causes its byte, plus the
// checksum on the last one.
// Result channel (out_*): one frame byte per item, last_of_run marks the last
// byte caused by an input item, end_of_frame marks the checksum.
// An accepted item is held in the sequencer, and each byte that it causes
// passes through the result register. Throughput: one result per cycle
// while out_stall is low, set by the single-byte result register; an item
// holds the input until its last byte is taken, and the next item can be
// accepted in that same cycle, so payload items flow at one per cycle.
// Reset (synchronous, rst_n low) empties both registers and returns to idle.
// When out_stall is high the result register holds its byte and the input
// stalls as soon as the held item cannot advance.
// ----------------------------------------------------------------------------
module api_tx16_frame_builder (
  input  logic                       clk,
  input  logic                       rst_n,
  input  logic                       in_valid,
  output logic                       in_stall,
  input  logic [atf_pkg::ADDR_W-1:0] in_dest_addr,
  input  logic [atf_pkg::LEN_W-1:0]  in_payload_len,
  input  logic [atf_pkg::BYTE_W-1:0] in_data_byte,
  output logic                       out_valid,
  input  logic                       out_stall,
  output logic [atf_pkg::BYTE_W-1:0] out_frame_byte,
  output logic                       out_last_of_run,
  output logic                       out_end_of_frame
);

  logic          emit_valid;
  logic          emit_ready;
  atf_pkg::res_t emit_res;

  atf_seq u_seq (
    .clk            (clk),
    .rst_n          (rst_n),
    .in_valid       (in_valid),
    .in_stall       (in_stall),
    .in_dest_addr   (in_dest_addr),
    .in_payload_len (in_payload_len),
    .in_data_byte   (in_data_byte),
    .emit_ready     (emit_ready),
    .emit_valid     (emit_valid),
    .emit_res       (emit_res)
  );

  atf_out_reg u_out_reg (
    .clk              (clk),
    .rst_n            (rst_n),
    .emit_valid       (emit_valid),
    .emit_res         (emit_res),
    .emit_ready       (emit_ready),
    .out_valid        (out_valid),
    .out_stall        (out_stall),
    .out_frame_byte   (out_frame_byte),
    .out_last_of_run  (out_last_of_run),
    .out_end_of_frame (out_end_of_frame)
  );

`ifndef SYNTHESIS
  a_csum_ends_run: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && out_end_of_frame |-> out_last_of_run)
    else $error("checksum byte does not end its run");

  a_accept_holds: assert property (@(posedge clk) disable iff (!rst_n)
    in_valid && !in_stall |=> emit_valid)
    else $error("accepted item not held in the sequencer");

  a_stall_needs_item: assert property (@(posedge clk) disable iff (!rst_n)
    in_stall |-> emit_valid)
    else $error("input stalled with no item held");
`endif

endmodule

@@ tb/api_tx16_frame_builder_tb.sv @@
`timescale 1ns / 100ps
// ----------------------------------------------------------------------------
// api_tx16_frame_builder_tb
// Self-checking bench for the API transmit frame builder.
// Frames go in one payload item at a time. A byte-level model of the framing
// builds the expected header, payload and checksum bytes for every accepted
// item, and each result byte is checked against them in order. The sender
// works in random bursts and the receiver stalls in changing patterns. One
// long output hold-off fills the block.
// ----------------------------------------------------------------------------
module api_tx16_frame_builder_tb;

  localparam int unsigned RANDOM_ITEMS = 240;
  localparam int unsigned HOLD_CYCLES  = 300;
  localparam int unsigned SETTLE_CYCLES = 16;

  typedef enum logic [1:0] {RX_FREE, RX_LIGHT, RX_HEAVY, RX_PATTERN} rx_mode_t;

  logic                         clk;
  logic                         rst_n          = 1'b0;
  logic                         in_valid       = 1'b0;
  logic                         in_stall;
  logic [atf_pkg::ADDR_W-1:0]   in_dest_addr   = '0;
  logic [atf_pkg::LEN_W-1:0]    in_payload_len = '0;
  logic [atf_pkg::BYTE_W-1:0]   in_data_byte   = '0;
  logic                         out_valid;
  logic                         out_stall      = 1'b0;
  logic [atf_pkg::BYTE_W-1:0]   out_frame_byte;
  logic                         out_last_of_run;
  logic                         out_end_of_frame;

  // frame tracker state
  logic                         frm_open = 1'b0;
  logic [atf_pkg::LEN_W-1:0]    frm_left = '0;
  logic [atf_pkg::BYTE_W-1:0]   frm_sum  = '0;
  atf_pkg::res_t                pending_bytes [$];
  atf_pkg::res_t                want;
  int unsigned                  err_count = 0;

  // receiver control
  logic                         hold_req  = 1'b0;
  logic                         hold_ack  = 1'b0;
  logic [15:0]                  hold_left = '0;
  rx_mode_t                     rx_mode   = RX_FREE;
  logic [7:0]                   rx_mode_left = '0;
  logic [7:0]                   rx_tick   = '0;

  // sender control
  int unsigned                  tx_burst_left = 0;
  logic                         fast_tx = 1'b0;

  api_tx16_frame_builder dut (
    .clk              (clk),
    .rst_n            (rst_n),
    .in_valid         (in_valid),
    .in_stall         (in_stall),
    .in_dest_addr     (in_dest_addr),
    .in_payload_len   (in_payload_len),
    .in_data_byte     (in_data_byte),
    .out_valid        (out_valid),
    .out_stall        (out_stall),
    .out_frame_byte   (out_frame_byte),
    .out_last_of_run  (out_last_of_run),
    .out_end_of_frame (out_end_of_frame)
  );

  initial begin
    clk = 1'b0;
    forever #2 clk = ~clk;
  end

  initial begin
    #3000000;
    $display("api_tx16_frame_builder test failed");
    $finish;
  end

  task automatic build_bytes(input logic [atf_pkg::ADDR_W-1:0] addr,
                             input logic [atf_pkg::LEN_W-1:0] len,
                             input logic [atf_pkg::BYTE_W-1:0] data);
    logic [atf_pkg::LEN_W-1:0]  flen;
    logic [atf_pkg::BYTE_W-1:0] run_b [$];
    logic                       closes;
    atf_pkg::res_t              r;
    closes = 1'b0;
    if (!frm_open) begin
      flen = len + atf_pkg::LEN_OVERHEAD;
      run_b = '{atf_pkg::START_BYTE, flen[15:8], flen[7:0], atf_pkg::API_ID_TX16,
                atf_pkg::FRAME_ID, addr[15:8], addr[7:0], atf_pkg::OPTIONS_BYTE};
      frm_sum = atf_pkg::API_ID_TX16 + atf_pkg::FRAME_ID + addr[15:8] + addr[7:0] +
                atf_pkg::OPTIONS_BYTE;
      frm_open = 1'b1;
      frm_left = len;
    end
    if (frm_left != 0) begin
      run_b.push_back(data);
      frm_sum = frm_sum + data;
      frm_left = frm_left - 1'b1;
    end
    if (frm_left == 0) begin
      run_b.push_back(atf_pkg::CSUM_BASE - frm_sum);
      closes = 1'b1;
      frm_open = 1'b0;
      frm_sum = '0;
    end
    for (int i = 0; i < run_b.size(); i++) begin
      r.frame_byte   = run_b[i];
      r.last_of_run  = (i == run_b.size() - 1);
      r.end_of_frame = closes && (i == run_b.size() - 1);
      pending_bytes.push_back(r);
    end
  endtask

  // predict on accepted input first, then check the accepted result
  always @(posedge clk) begin
    if (!rst_n) begin
      frm_open <= 1'b0;
      frm_left <= '0;
      frm_sum  <= '0;
    end else begin
      if (in_valid && !in_stall) begin
        build_bytes(in_dest_addr, in_payload_len, in_data_byte);
      end
      if (out_valid && !out_stall) begin
        if (pending_bytes.size() == 0) begin
          $error("unexpected result: frame_byte %0h", out_frame_byte);
          err_count++;
        end else begin
          want = pending_bytes.pop_front();
          if (out_frame_byte !== want.frame_byte) begin
            $error("frame_byte: expected %0h, got %0h", want.frame_byte, out_frame_byte);
            err_count++;
          end
          if (out_last_of_run !== want.last_of_run) begin
            $error("last_of_run: expected %0b, got %0b", want.last_of_run, out_last_of_run);
            err_count++;
          end
          if (out_end_of_frame !== want.end_of_frame) begin
            $error("end_of_frame: expected %0b, got %0b", want.end_of_frame,
                   out_end_of_frame);
            err_count++;
          end
        end
      end
    end
  end

  always @(posedge clk) begin
    if (!rst_n) begin
      out_stall    <= 1'b0;
      hold_ack     <= 1'b0;
      hold_left    <= '0;
      rx_mode      <= RX_FREE;
      rx_mode_left <= '0;
      rx_tick      <= '0;
    end else begin
      rx_tick <= rx_tick + 1'b1;
      if (hold_req != hold_ack) begin
        hold_ack  <= hold_req;
        hold_left <= 16'(HOLD_CYCLES);
        out_stall <= 1'b1;
      end else if (hold_left != 0) begin
        hold_left <= hold_left - 1'b1;
        out_stall <= 1'b1;
      end else begin
        if (rx_mode_left == 0) begin
          rx_mode      <= rx_mode_t'($urandom_range(3, 0));
          rx_mode_left <= 8'($urandom_range(96, 16));
        end else begin
          rx_mode_left <= rx_mode_left - 1'b1;
        end
        case (rx_mode)
          RX_FREE:  out_stall <= 1'b0;
          RX_LIGHT: out_stall <= ($urandom_range(3, 0) == 0);
          RX_HEAVY: out_stall <= ($urandom_range(3, 0) != 0);
          default:  out_stall <= rx_tick[2] ^ rx_tick[0];
        endcase
      end
    end
  end

  task automatic send_item(input logic [atf_pkg::ADDR_W-1:0] addr,
                           input logic [atf_pkg::LEN_W-1:0] len,
                           input logic [atf_pkg::BYTE_W-1:0] data);
    int unsigned gap;
    if (!fast_tx && tx_burst_left == 0) begin
      tx_burst_left = $urandom_range(16, 1);
      gap = $urandom_range(6, 1);
      in_valid <= 1'b0;
      repeat (gap) @(posedge clk);
    end
    if (tx_burst_left != 0) tx_burst_left--;
    in_valid       <= 1'b1;
    in_dest_addr   <= addr;
    in_payload_len <= len;
    in_data_byte   <= data;
    do @(posedge clk); while (in_stall);
  endtask

  task automatic send_tail(input int unsigned count);
    for (int unsigned i = 0; i < count; i++) begin
      send_item(16'($urandom_range(16'hFFFF, 0)), 16'($urandom_range(16'hFFFF, 0)),
                8'($urandom_range(8'hFF, 0)));
    end
  endtask

  task automatic wait_drained();
    in_valid <= 1'b0;
    tx_burst_left = 0;
    do @(posedge clk); while (pending_bytes.size() != 0);
  endtask

  task automatic test_empty_frames();
    send_item(16'h0000, 16'd0, 8'hFF);
    send_item(16'hFFFF, 16'd0, 8'h00);
    // sum of summed header bytes is 0xFF, so checksum is zero
    send_item(16'h00FD, 16'd0, 8'h5A);
    wait_drained();
  endtask

  task automatic test_one_byte_frames();
    send_item(16'h1234, 16'd1, 8'h00);
    send_item(16'hABCD, 16'd1, 8'hFF);
    // payload wraps the sum to zero, so checksum is 0xFF
    send_item(16'h0000, 16'd1, 8'hFE);
    wait_drained();
  endtask

  task automatic test_short_frames();
    send_item(16'hFFFF, 16'd3, 8'hFF);
    send_item(16'h0000, 16'hFFFF, 8'h00);
    send_item(16'hFFFF, 16'h0000, 8'h80);
    send_item(16'h8001, 16'd2, 8'h01);
    send_item(16'h7FFE, 16'd1, 8'h7F);
    wait_drained();
  endtask

  task automatic test_random_frames();
    int unsigned sent;
    int unsigned pick;
    int unsigned len;
    sent = 0;
    while (sent < RANDOM_ITEMS) begin
      pick = $urandom_range(99, 0);
      if (pick < 20)      len = 0;
      else if (pick < 40) len = 1;
      else if (pick < 85) len = $urandom_range(8, 2);
      else                len = $urandom_range(40, 9);
      send_item(16'($urandom_range(16'hFFFF, 0)), 16'(len), 8'($urandom_range(8'hFF, 0)));
      sent++;
      if (len > 1) begin
        send_tail(len - 1);
        sent += len - 1;
      end
    end
    wait_drained();
  endtask

  task automatic test_output_holdoff();
    fast_tx = 1'b1;
    hold_req <= ~hold_req;
    send_item(16'h5AA5, 16'd24, 8'($urandom_range(8'hFF, 0)));
    send_tail(23);
    fast_tx = 1'b0;
    wait_drained();
  endtask

  initial begin
    repeat (6) @(posedge clk);
    rst_n <= 1'b1;
    @(posedge clk);
    test_empty_frames();
    test_one_byte_frames();
    test_short_frames();
    test_random_frames();
    test_output_holdoff();
    wait_drained();
    repeat (SETTLE_CYCLES) @(posedge clk);
    if (err_count == 0) begin
      $display("api_tx16_frame_builder test passed");
    end else begin
      $display("api_tx16_frame_builder test failed");
    end
    $finish;
  end

endmodule
